[sv/assert_macros.svh]
// Assertion macros used by sorted_id_packet_table_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SIPT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SIPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SIPT_ASSERT(lbl, clk, rst_n, prop, msg)

`define SIPT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[sv/sipt_pkg.sv]
// Types and codes for the sorted id packet table.
package sipt_pkg;

	typedef logic [1:0] cmd_t;
	typedef logic [1:0] stat_t;

	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_TAKE   = 2'd1;
	localparam cmd_t CMD_READ   = 2'd2;

	localparam stat_t STAT_OK      = 2'd0;
	localparam stat_t STAT_FULL    = 2'd1;
	localparam stat_t STAT_MISSING = 2'd2;

	localparam logic [4:0] CAP_RESET = 5'd16;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] packet_id;
		logic [31:0] payload;
	} in_item_t;

	typedef struct packed {
		stat_t       status;
		logic [31:0] found_id;
		logic [31:0] found_payload;
		logic [4:0]  entry_count;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_INS_CHK,
		S_SRCH,
		S_SHF,
		S_DONE
	} state_t;

endpackage

[sv/sipt_mem.sv]
// Entry storage: one write port, one registered read port.
module sipt_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 64
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/sipt_seq.sv]
// Sequencer: scans, shifts and compares entries one memory access a cycle.
module sipt_seq #(
	parameter int DEPTH        = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  sipt_pkg::in_item_t                   item,
	input  logic [4:0]                           cap,
	output logic                                 idle,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output sipt_pkg::out_item_t                  res,
	output logic                                 mem_we,
	output logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] mem_waddr,
	output logic [32+PAYLOAD_BITS-1:0]           mem_wdata,
	output logic                                 mem_re,
	output logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] mem_raddr,
	input  logic [32+PAYLOAD_BITS-1:0]           mem_rdata
);

	import sipt_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > 5) ? CW : 5;
	localparam int PB = PAYLOAD_BITS;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q;
	logic            rv_q;
	cmd_t            cmd_q;
	logic [31:0]     key_q;
	logic [PB-1:0]   pay_q;
	logic [CW-1:0]   a_q;
	logic [CW-1:0]   p_q;
	stat_t           status_q;
	logic [31:0]     fid_q;
	logic [31:0]     fpay_q;

	logic [63:0]     pin_ext;
	logic [PB-1:0]   pay_in;
	logic [31:0]     rd_id;
	logic [PB-1:0]   rd_pay;
	logic [63:0]     rd_pay_ext;
	logic [CW-1:0]   a_m1, a_m2, p_m1;
	logic [31:0]     cnt_ext;
	logic            full, more, hit, ge;
	logic            cnt_inc, cnt_dec;

	assign pin_ext    = 64'(item.payload);
	assign pay_in     = pin_ext[PB-1:0];
	assign rd_id      = mem_rdata[PB +: 32];
	assign rd_pay     = mem_rdata[PB-1:0];
	assign rd_pay_ext = 64'(rd_pay);
	assign a_m1       = a_q - CW'(1);
	assign a_m2       = a_q - CW'(2);
	assign p_m1       = p_q - CW'(1);
	assign cnt_ext    = 32'(cnt_q);

	assign full = (LW'(cnt_q) >= LW'(cap)) || (cnt_q >= DEPTH_C);
	assign more = a_q < cnt_q;
	assign hit  = rv_q && (rd_id == key_q);
	assign ge   = rd_id >= key_q;

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = a_q[AW-1:0];
		mem_wdata = {key_q, pay_q};
		mem_re    = 1'b0;
		mem_raddr = a_q[AW-1:0];
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (item.command)
						CMD_INSERT:        state_d = full ? S_DONE : S_INS;
						CMD_TAKE, CMD_READ: state_d = (cnt_q == '0) ? S_DONE : S_SRCH;
						default:           state_d = S_DONE;
					endcase
				end
			end
			S_INS: begin
				if (a_q == '0) begin
					mem_we  = 1'b1;
					cnt_inc = 1'b1;
					state_d = S_DONE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = a_m1[AW-1:0];
					state_d   = S_INS_CHK;
				end
			end
			S_INS_CHK: begin
				mem_we = 1'b1;
				if (ge) begin
					mem_wdata = mem_rdata;
					if (a_m1 != '0) begin
						mem_re    = 1'b1;
						mem_raddr = a_m2[AW-1:0];
					end else begin
						state_d = S_INS;
					end
				end else begin
					cnt_inc = 1'b1;
					state_d = S_DONE;
				end
			end
			S_SRCH: begin
				mem_re = more;
				if (hit) begin
					state_d = (cmd_q == CMD_TAKE) ? S_SHF : S_DONE;
				end else if (!more) begin
					state_d = S_DONE;
				end
			end
			S_SHF: begin
				mem_re = more;
				if (rv_q) begin
					mem_we    = 1'b1;
					mem_waddr = p_m1[AW-1:0];
					mem_wdata = mem_rdata;
				end else begin
					cnt_dec = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_q    <= (state_q == S_SRCH || state_q == S_SHF) && more;
			if (cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q  <= item.command;
					key_q  <= item.packet_id;
					pay_q  <= pay_in;
					a_q    <= (item.command == CMD_INSERT) ? cnt_q : '0;
					fid_q  <= '0;
					fpay_q <= '0;
					if (item.command == CMD_INSERT) begin
						status_q <= full ? STAT_FULL : STAT_OK;
					end else begin
						status_q <= STAT_MISSING;
					end
				end
			end
			S_INS_CHK: begin
				if (ge) begin
					a_q <= a_m1;
				end
			end
			S_SRCH, S_SHF: begin
				if (more) begin
					a_q <= a_q + CW'(1);
					p_q <= a_q;
				end
				if (state_q == S_SRCH && hit) begin
					status_q <= STAT_OK;
					fid_q    <= rd_id;
					fpay_q   <= rd_pay_ext[31:0];
				end
			end
			default: ;
		endcase
	end

	assign idle              = (state_q == S_IDLE);
	assign res.status        = status_q;
	assign res.found_id      = fid_q;
	assign res.found_payload = fpay_q;
	assign res.entry_count   = cnt_ext[4:0];

endmodule

[sv/sorted_id_packet_table_unit.sv]
// Sorted id packet table: insert, take and read packets kept in ascending id order.
//
// Channels: the input channel (in_valid, in_ready, in_data) carries a command, an id
// and a payload; the output channel (out_valid, out_ready, out_data) returns one result
// per command with status, found id and payload, and the entry count afterwards.
// cfg_wr_en / cfg_wr_data write the capacity register; the user must write it only
// while idle, as the block itself does not enforce this. An insert shifts each stored
// entry whose id is not below the new one up one place, from the end, then writes the
// new entry; a read or take scans from the first entry to the match, and a take then
// shifts the later entries down; a miss scans every entry; a full insert, empty lookup
// or reserved command goes straight to the result. Throughput is one command at a
// time, bounded by the single memory read port that visits one entry per cycle.
// Reset clears the entry count and sets the capacity to 16; the storage is left as is.
// A finished result waits in the output register while the next command is accepted;
// if the receiver stalls, the following command holds at its end until the register
// drains.
module sorted_id_packet_table_unit #(
	parameter int DEPTH        = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sipt_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sipt_pkg::out_item_t out_data,
	input  logic                cfg_wr_en,
	input  logic [4:0]          cfg_wr_data
);

	import sipt_pkg::*;

	`include "assert_macros.svh"

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int W  = 32 + PAYLOAD_BITS;

	logic [4:0] capacity_q;
	logic       out_valid_q;
	out_item_t  out_data_q;

	logic       start, seq_idle, res_valid, res_ready;
	out_item_t  res;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [W-1:0]  mem_wdata, mem_rdata;

	assign in_ready  = seq_idle;
	assign start     = in_valid && in_ready;
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	sipt_seq #(
		.DEPTH        (DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (in_data),
		.cap       (capacity_q),
		.idle      (seq_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	sipt_mem #(
		.DEPTH (DEPTH),
		.WIDTH (W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	`SIPT_ASSERT(a_busy_after_transfer, clk, arst_n, start |=> !in_ready, "ready held after input transfer")
	`SIPT_ASSERT(a_status_code, clk, arst_n, out_valid_q |-> (out_data_q.status == STAT_OK || out_data_q.status == STAT_FULL || out_data_q.status == STAT_MISSING), "undefined status code")
	`SIPT_ASSERT(a_fail_zero_fields, clk, arst_n, (out_valid_q && out_data_q.status != STAT_OK) |-> (out_data_q.found_id == '0 && out_data_q.found_payload == '0), "failed result carries entry data")
	`SIPT_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !out_valid_q, "result visible during reset")

endmodule
